FILE: rtl/hte_pkg.sv
// ----------------------------------------------------------------------------
// hte_pkg
// Shared types and constants of the Huffman table encoder and bit packer.
// ----------------------------------------------------------------------------
package hte_pkg;

  // Packed word width and number of table entries
  localparam int WORD_BITS    = 32;
  localparam int SYMBOL_COUNT = 256;

  // Fixed port widths
  localparam int SYM_W       = 8;
  localparam int CODE_LEN_W  = 6;
  localparam int CODE_BITS_W = 32;
  localparam int ACTION_W    = 2;

  // Derived widths
  localparam int ADDR_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LEN_W  = $clog2(WORD_BITS + 1);

  // Reset value of the end symbol register
  localparam logic [SYM_W-1:0] END_SYMBOL_RESET = SYM_W'(3);

  // Queue depths, powers of two
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  // Input action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FINISH = 2'd2
  } action_e;

  // Command kinds passed from front to back
  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_kind_e;

  // Back end sequencing
  typedef enum logic {
    BK_APPEND = 1'b0,
    BK_FLUSH  = 1'b1
  } back_state_e;

  // One code table entry
  typedef struct packed {
    logic [LEN_W-1:0]     len;
    logic [WORD_BITS-1:0] code;
  } tbl_entry_t;

  // Command carried through the middle queue
  typedef struct packed {
    cmd_kind_e  kind;
    tbl_entry_t entry;
  } cmd_t;

  // Middle queue status seen by the front end
  typedef struct packed {
    logic                  valid;
    logic [CMDQ_CNT_W-1:0] level;
  } cmdq_status_t;

  // One result word
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 last;
  } out_t;

endpackage

FILE: rtl/hte_front.sv
// ----------------------------------------------------------------------------
// hte_front
// Accepts items, holds the code table and the end symbol, looks up codes.
// ----------------------------------------------------------------------------
module hte_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [hte_pkg::ACTION_W-1:0]  action_i,
  input  logic [hte_pkg::SYM_W-1:0]     symbol_i,
  input  logic [hte_pkg::CODE_LEN_W-1:0]  code_len_i,
  input  logic [hte_pkg::CODE_BITS_W-1:0] code_bits_i,
  input  logic                          cfg_valid_i,
  input  logic [hte_pkg::SYM_W-1:0]     cfg_data_i,
  input  hte_pkg::cmdq_status_t         cmdq_status_i,
  output logic                          cmd_push_o,
  output hte_pkg::cmd_t                 cmd_o
);
  import hte_pkg::*;

  logic [SYM_W-1:0]     end_sym_q;
  logic                 accept;
  logic                 wr_en;
  logic                 rd_en;
  logic                 lk_valid;
  logic                 lk_hit;
  logic [SYM_W-1:0]     rd_sym;
  cmd_kind_e            lk_kind;
  tbl_entry_t           wr_entry;
  tbl_entry_t           rd_data_q;
  tbl_entry_t           code_mem [SYMBOL_COUNT];
  logic                 s1_valid_q;
  logic                 s1_hit_q;
  cmd_kind_e            s1_kind_q;
  logic [CMDQ_CNT_W:0]  occ;
  logic [WORD_BITS-1:0] code_ext;

  // Stall when the middle queue could not absorb the lookup stage
  assign occ    = {1'b0, cmdq_status_i.level} + {{CMDQ_CNT_W{1'b0}}, s1_valid_q};
  assign full_o = (occ >= (CMDQ_CNT_W+1)'(CMDQ_DEPTH));
  assign accept = push_i && !full_o;

  // End symbol register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_sym_q <= END_SYMBOL_RESET;
    end else if (cfg_valid_i) begin
      end_sym_q <= cfg_data_i;
    end
  end

  // Build a table entry: saturate the length, drop stray code bits
  always_comb begin
    code_ext = WORD_BITS'(code_bits_i);
    if (int'(code_len_i) > WORD_BITS) begin
      wr_entry.len = LEN_W'(WORD_BITS);
    end else begin
      wr_entry.len = LEN_W'(code_len_i);
    end
    wr_entry.code = code_ext & ~({WORD_BITS{1'b1}} << wr_entry.len);
  end

  // Classify the transaction
  always_comb begin
    wr_en    = 1'b0;
    lk_valid = 1'b0;
    lk_hit   = 1'b0;
    rd_sym   = symbol_i;
    lk_kind  = CMD_ENCODE;
    case (action_e'(action_i))
      ACT_LOAD: begin
        wr_en = accept && (int'(symbol_i) < SYMBOL_COUNT);
      end
      ACT_ENCODE: begin
        lk_valid = accept && (int'(symbol_i) < SYMBOL_COUNT);
        lk_hit   = 1'b1;
      end
      ACT_FINISH: begin
        rd_sym   = end_sym_q;
        lk_kind  = CMD_FINISH;
        lk_valid = accept;
        lk_hit   = (int'(end_sym_q) < SYMBOL_COUNT);
      end
      default: begin
      end
    endcase
  end

  assign rd_en = lk_valid && lk_hit;

  // Code table, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      code_mem[symbol_i[ADDR_W-1:0]] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_q <= code_mem[rd_sym[ADDR_W-1:0]];
    end
  end

  // Lookup stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_hit_q   <= 1'b0;
      s1_kind_q  <= CMD_ENCODE;
    end else begin
      s1_valid_q <= lk_valid;
      s1_hit_q   <= lk_hit;
      s1_kind_q  <= lk_kind;
    end
  end

  // Forward to the middle queue; an out-of-range end symbol adds no code
  assign cmd_push_o = s1_valid_q;
  assign cmd_o.kind  = s1_kind_q;
  assign cmd_o.entry = s1_hit_q ? rd_data_q : '0;

endmodule

FILE: rtl/hte_cmd_queue.sv
// ----------------------------------------------------------------------------
// hte_cmd_queue
// Short command queue that decouples the lookup front from the packer.
// ----------------------------------------------------------------------------
module hte_cmd_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  hte_pkg::cmd_t         cmd_i,
  input  logic                  pop_i,
  output hte_pkg::cmdq_status_t status_o,
  output hte_pkg::cmd_t         cmd_o
);
  import hte_pkg::*;

  cmd_t                  q_mem [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q;
  logic [CMDQ_CNT_W-1:0] cnt_q;
  logic                  do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem[wr_ptr_q] <= cmd_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + CMDQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + CMDQ_PTR_W'(1);
      end
      case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + CMDQ_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CMDQ_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign status_o.valid = (cnt_q != '0);
  assign status_o.level = cnt_q;
  assign cmd_o          = q_mem[rd_ptr_q];

endmodule

FILE: rtl/hte_back.sv
// ----------------------------------------------------------------------------
// hte_back
// Bit packer: appends codes to the accumulator and queues finished words.
// ----------------------------------------------------------------------------
module hte_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  hte_pkg::cmd_t                 cmd_i,
  output logic                          cmd_pop_o,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [hte_pkg::WORD_BITS-1:0] packed_word_o,
  output logic                          last_word_o
);
  import hte_pkg::*;

  back_state_e           state_q, state_d;
  logic [WORD_BITS-1:0]  acc_q, acc_d;
  logic [LEN_W-1:0]      fill_q, fill_d;
  logic [LEN_W-1:0]      room;
  logic [LEN_W-1:0]      over;
  logic                  hit;
  logic [WORD_BITS-1:0]  app_word;
  logic [WORD_BITS-1:0]  app_acc;
  logic [LEN_W-1:0]      app_fill;
  logic [WORD_BITS-1:0]  flush_app;
  logic [WORD_BITS-1:0]  flush_cur;
  logic                  can_push;
  logic                  run;
  logic                  ob_push;
  out_t                  ob_data;
  out_t                  out_mem [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] owr_ptr_q;
  logic [OUTQ_PTR_W-1:0] ord_ptr_q;
  logic [OUTQ_CNT_W-1:0] ocnt_q;
  logic                  out_pop;
  out_t                  head;

  assign can_push = (ocnt_q != OUTQ_CNT_W'(OUTQ_DEPTH));
  assign run      = cmd_valid_i && can_push;

  // Append the code of the head command
  always_comb begin
    room     = LEN_W'(WORD_BITS) - fill_q;
    hit      = (cmd_i.entry.len >= room);
    over     = cmd_i.entry.len - room;
    app_word = (acc_q << room) | (cmd_i.entry.code >> over);
    if (hit) begin
      app_acc  = cmd_i.entry.code & ~({WORD_BITS{1'b1}} << over);
      app_fill = over;
    end else begin
      app_acc  = (acc_q << cmd_i.entry.len) | cmd_i.entry.code;
      app_fill = fill_q + cmd_i.entry.len;
    end
    flush_app = app_acc << (LEN_W'(WORD_BITS) - app_fill);
    flush_cur = acc_q << (LEN_W'(WORD_BITS) - fill_q);
  end

  // Next state: a finish that yields two words takes a flush step
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_APPEND: begin
        if (run && (cmd_i.kind == CMD_FINISH) && hit && (app_fill != '0)) begin
          state_d = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (can_push) begin
          state_d = BK_APPEND;
        end
      end
      default: state_d = BK_APPEND;
    endcase
  end

  // Outputs of each step
  always_comb begin
    ob_push      = 1'b0;
    ob_data.word = app_word;
    ob_data.last = 1'b0;
    cmd_pop_o    = 1'b0;
    acc_d        = acc_q;
    fill_d       = fill_q;
    case (state_q)
      BK_APPEND: begin
        if (run) begin
          if (cmd_i.kind == CMD_ENCODE) begin
            ob_push   = hit;
            acc_d     = app_acc;
            fill_d    = app_fill;
            cmd_pop_o = 1'b1;
          end else if (hit && (app_fill != '0)) begin
            // Word filled and bits remain: hold the command for the flush
            ob_push = 1'b1;
            acc_d   = app_acc;
            fill_d  = app_fill;
          end else begin
            if (hit) begin
              ob_push      = 1'b1;
              ob_data.last = 1'b1;
            end else if (app_fill != '0) begin
              ob_push      = 1'b1;
              ob_data.word = flush_app;
              ob_data.last = 1'b1;
            end
            acc_d     = '0;
            fill_d    = '0;
            cmd_pop_o = 1'b1;
          end
        end
      end
      BK_FLUSH: begin
        if (can_push) begin
          ob_push      = 1'b1;
          ob_data.word = flush_cur;
          ob_data.last = 1'b1;
          acc_d        = '0;
          fill_d       = '0;
          cmd_pop_o    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Packer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_APPEND;
      acc_q   <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      fill_q  <= fill_d;
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (ob_push) begin
      out_mem[owr_ptr_q] <= ob_data;
    end
  end

  assign out_pop = pop_i && (ocnt_q != '0);

  // Result queue pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_ptr_q <= '0;
      ord_ptr_q <= '0;
      ocnt_q    <= '0;
    end else begin
      if (ob_push) begin
        owr_ptr_q <= owr_ptr_q + OUTQ_PTR_W'(1);
      end
      if (out_pop) begin
        ord_ptr_q <= ord_ptr_q + OUTQ_PTR_W'(1);
      end
      case ({ob_push, out_pop})
        2'b10:   ocnt_q <= ocnt_q + OUTQ_CNT_W'(1);
        2'b01:   ocnt_q <= ocnt_q - OUTQ_CNT_W'(1);
        default: ocnt_q <= ocnt_q;
      endcase
    end
  end

  assign head          = out_mem[ord_ptr_q];
  assign empty_o       = (ocnt_q == '0);
  assign packed_word_o = head.word;
  assign last_word_o   = head.last;

endmodule

FILE: rtl/huffman_table_encoder_packer_core.sv
// ----------------------------------------------------------------------------
// huffman_table_encoder_packer_core
// Huffman encoder with a loadable 256-entry code table and a 32-bit packer.
// ----------------------------------------------------------------------------
// The block takes one transaction per cycle while full is low: a table load,
// a symbol to encode or a finish. A load writes the code table at the edge
// that accepts it; an encode or finish reads the table at its accepting edge
// (registered memory read). Its word passes the lookup stage register and
// the command queue, then the packer queues it and empty falls. The packer
// handles one command per cycle while the result queue has room; a finish
// that yields both a filled word and a flushed last word adds a flush step.
// A four deep command queue sits between lookup and packer, and a four deep
// result queue holds finished words, so either side may stall.
// The table has no reset and must be loaded before a symbol is encoded.
// The end symbol register (reset 3) is written through the cfg channel,
// which is always ready; write it only while the block is idle.
module huffman_table_encoder_packer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [hte_pkg::ACTION_W-1:0]    action_i,
  input  logic [hte_pkg::SYM_W-1:0]       symbol_i,
  input  logic [hte_pkg::CODE_LEN_W-1:0]  code_len_i,
  input  logic [hte_pkg::CODE_BITS_W-1:0] code_bits_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [hte_pkg::WORD_BITS-1:0]   packed_word_o,
  output logic                            last_word_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hte_pkg::SYM_W-1:0]       cfg_data_i
);
  import hte_pkg::*;

  cmdq_status_t cmdq_status;
  cmd_t         front_cmd;
  cmd_t         head_cmd;
  logic         front_push;
  logic         back_pop;

  assign cfg_ready_o = 1'b1;

  // Accept, classify and look up
  hte_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .action_i      (action_i),
    .symbol_i      (symbol_i),
    .code_len_i    (code_len_i),
    .code_bits_i   (code_bits_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .cmdq_status_i (cmdq_status),
    .cmd_push_o    (front_push),
    .cmd_o         (front_cmd)
  );

  // Decouple lookup from packing
  hte_cmd_queue u_cmd_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (front_push),
    .cmd_i    (front_cmd),
    .pop_i    (back_pop),
    .status_o (cmdq_status),
    .cmd_o    (head_cmd)
  );

  // Pack codes into words
  hte_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmdq_status.valid),
    .cmd_i         (head_cmd),
    .cmd_pop_o     (back_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .packed_word_o (packed_word_o),
    .last_word_o   (last_word_o)
  );

endmodule

FILE: rtl/hte_checker.sv
// ----------------------------------------------------------------------------
// hte_checker
// Port-level checks of the encoder core, bound to the top level.
// ----------------------------------------------------------------------------
module hte_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          push,
  input logic                          full,
  input logic                          pop,
  input logic                          empty,
  input logic [hte_pkg::WORD_BITS-1:0] packed_word_o,
  input logic                          last_word_o
);
  import hte_pkg::*;

  // Hold the result queue empty and full low while in reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> (empty && !full))
    else $error("queues not empty during reset");

  // Hold a waiting result until it is popped
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(packed_word_o) && $stable(last_word_o)))
    else $error("waiting result changed before pop");

  // Drop no waiting result
  a_result_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("waiting result lost");

  // Back pressure rises only after an accepted transaction
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full raised without a transaction");

endmodule

bind huffman_table_encoder_packer_core hte_checker u_hte_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .push          (push),
  .full          (full),
  .pop           (pop),
  .empty         (empty),
  .packed_word_o (packed_word_o),
  .last_word_o   (last_word_o)
);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Huffman table encoder and 32-bit bit packer.
// A directed part loads the code table and exercises full-word codes,
// saturated and zero lengths, stray code bits, finish with zero, one and two
// words, and end symbol updates. A long random part follows, using table
// loads, symbol streams and finishes with random idling on both queue sides
// and one long hold-off of the result side. Every popped word is checked
// against a cycle-free model of the packer.
// ----------------------------------------------------------------------------
module tb_top;
  import hte_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int IDLE_PCT      = 14;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   push;
  logic                   full;
  logic [ACTION_W-1:0]    action_i;
  logic [SYM_W-1:0]       symbol_i;
  logic [CODE_LEN_W-1:0]  code_len_i;
  logic [CODE_BITS_W-1:0] code_bits_i;
  logic                   empty;
  logic                   pop;
  logic [WORD_BITS-1:0]   packed_word_o;
  logic                   last_word_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [SYM_W-1:0]       cfg_data_i;

  // Packer model state
  logic [CODE_LEN_W-1:0]  code_len_tbl [SYMBOL_COUNT];
  logic [WORD_BITS-1:0]   code_val_tbl [SYMBOL_COUNT];
  bit                     loaded [SYMBOL_COUNT];
  logic [SYM_W-1:0]       loaded_syms [$];
  logic [WORD_BITS-1:0]   acc_bits = '0;
  int                     acc_fill = 0;
  logic [SYM_W-1:0]       end_sym = END_SYMBOL_RESET;
  out_t                   pending_words [$];

  int errors       = 0;
  bit calm         = 1'b0;
  int hold_request = 0;
  int cycles       = 0;

  huffman_table_encoder_packer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .symbol_i      (symbol_i),
    .code_len_i    (code_len_i),
    .code_bits_i   (code_bits_i),
    .empty         (empty),
    .pop           (pop),
    .packed_word_o (packed_word_o),
    .last_word_o   (last_word_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Keep the low n bits of a code
  function automatic logic [WORD_BITS-1:0] low_bits(logic [WORD_BITS-1:0] v, int n);
    return WORD_BITS'(64'(v) & ((64'd1 << n) - 64'd1));
  endfunction

  // Append one code; return 1 with the filled word when the accumulator fills
  function automatic bit append_code(input logic [CODE_LEN_W-1:0] len,
                                     input logic [WORD_BITS-1:0] code,
                                     output logic [WORD_BITS-1:0] word);
    int room;
    int over;
    room = WORD_BITS - acc_fill;
    word = '0;
    if (len < room) begin
      acc_bits = WORD_BITS'((64'(acc_bits) << len) | 64'(code));
      acc_fill += len;
      return 1'b0;
    end
    over     = len - room;
    word     = WORD_BITS'((64'(acc_bits) << room) | (64'(code) >> over));
    acc_bits = low_bits(code, over);
    acc_fill = over;
    return 1'b1;
  endfunction

  // Advance the packer model by one accepted transaction
  function automatic void predict_words(logic [ACTION_W-1:0] act, logic [SYM_W-1:0] sym,
                                        logic [CODE_LEN_W-1:0] len,
                                        logic [CODE_BITS_W-1:0] bits);
    logic [CODE_LEN_W-1:0] sat;
    logic [WORD_BITS-1:0]  word;
    logic [WORD_BITS-1:0]  words [2];
    int                    n;
    n = 0;
    case (act)
      ACT_LOAD: begin
        sat = (len > WORD_BITS) ? CODE_LEN_W'(WORD_BITS) : len;
        code_len_tbl[sym] = sat;
        code_val_tbl[sym] = low_bits(bits, sat);
        if (!loaded[sym]) begin
          loaded[sym] = 1'b1;
          loaded_syms.push_back(sym);
        end
      end
      ACT_ENCODE: begin
        if (append_code(code_len_tbl[sym], code_val_tbl[sym], word))
          pending_words.push_back({word, 1'b0});
      end
      ACT_FINISH: begin
        if (append_code(code_len_tbl[end_sym], code_val_tbl[end_sym], word)) begin
          words[n] = word;
          n++;
        end
        if (acc_fill != 0) begin
          words[n] = WORD_BITS'(64'(acc_bits) << (WORD_BITS - acc_fill));
          n++;
        end
        for (int k = 0; k < n; k++)
          pending_words.push_back({words[k], k == n - 1});
        acc_bits = '0;
        acc_fill = 0;
      end
      default: ;
    endcase
  endfunction

  // Offer one transaction, hold it until accepted, then predict its words
  task automatic send_item(logic [ACTION_W-1:0] act, logic [SYM_W-1:0] sym,
                           logic [CODE_LEN_W-1:0] len, logic [CODE_BITS_W-1:0] bits);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    push        <= 1'b1;
    action_i    <= act;
    symbol_i    <= sym;
    code_len_i  <= len;
    code_bits_i <= bits;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_words(act, sym, len, bits);
  endtask

  // Hold the input until every expected word has arrived and the pipe is empty
  task automatic wait_drain();
    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the end symbol register; call only while idle
  task automatic write_end_symbol(logic [SYM_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    end_sym = v;
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly short codes, with zero, full-word and saturating lengths mixed in
  function automatic logic [CODE_LEN_W-1:0] random_len();
    int r;
    r = $urandom_range(99);
    if (r < 5)  return '0;
    if (r < 80) return CODE_LEN_W'($urandom_range(1, 12));
    if (r < 90) return CODE_LEN_W'($urandom_range(13, 31));
    if (r < 95) return CODE_LEN_W'(WORD_BITS);
    return CODE_LEN_W'($urandom_range(33, 63));
  endfunction

  // Table loads with extreme entries, then encodes over them
  task automatic test_load_and_encode();
    send_item(ACT_LOAD, 8'd0,   6'd32, 32'hFFFF_FFFF);
    send_item(ACT_LOAD, 8'd255, 6'd1,  32'h0000_0001);
    send_item(ACT_LOAD, 8'd3,   6'd5,  32'hFFFF_FFF5);  // stray high bits drop
    send_item(ACT_LOAD, 8'd7,   6'd63, 32'hA5A5_A5A5);  // length saturates
    send_item(ACT_LOAD, 8'd9,   6'd0,  32'h1234_5678);  // empty code
    send_item(ACT_LOAD, 8'd128, 6'd31, 32'h7FFF_FFFF);
    send_item(ACT_ENCODE, 8'd0, 6'd0, 32'h0);    // full word into empty accumulator
    send_item(ACT_ENCODE, 8'd9, 6'd63, 32'hFFFF_FFFF);
    send_item(ACT_ENCODE, 8'd255, 6'd0, 32'h0);
    send_item(ACT_ENCODE, 8'd7, 6'd0, 32'h0);    // one bit carries over
    send_item(ACT_UNUSED, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
    send_item(ACT_ENCODE, 8'd128, 6'd0, 32'h0);
  endtask

  // Finish with one result, then with a pending word split across two results
  task automatic test_finish_cases();
    send_item(ACT_FINISH, 8'd0, 6'd0, 32'h0);
    send_item(ACT_ENCODE, 8'd128, 6'd0, 32'h0);
    send_item(ACT_FINISH, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
    wait_drain();
  endtask

  // Sweep the end symbol: empty end code, full-word end code, top index
  task automatic test_end_symbol();
    write_end_symbol(8'd9);
    send_item(ACT_FINISH, 8'd0, 6'd0, 32'h0);    // nothing pending, no word
    send_item(ACT_ENCODE, 8'd255, 6'd0, 32'h0);
    send_item(ACT_FINISH, 8'd0, 6'd0, 32'h0);
    wait_drain();
    write_end_symbol(8'd0);
    send_item(ACT_ENCODE, 8'd255, 6'd0, 32'h0);
    send_item(ACT_FINISH, 8'd0, 6'd0, 32'h0);
    wait_drain();
    write_end_symbol(8'd255);
    send_item(ACT_ENCODE, 8'd128, 6'd0, 32'h0);
    send_item(ACT_FINISH, 8'd0, 6'd0, 32'h0);
    wait_drain();
    write_end_symbol(END_SYMBOL_RESET);
  endtask

  // Stall the result side long enough to fill both queues
  task automatic test_backpressure();
    hold_request = 80;
    repeat (24) send_item(ACT_ENCODE, 8'd0, 6'($urandom), $urandom);
    wait_drain();
  endtask

  // Random streams of loads, encodes and finishes, with some noise
  task automatic test_random_stream();
    int               i;
    int               r;
    int               next_cfg;
    logic [SYM_W-1:0] s;
    i        = 0;
    next_cfg = 250;
    while (i < RANDOM_ITEMS) begin
      calm = (i >= 500 && i < 800);
      if (i >= next_cfg) begin
        next_cfg += 250;
        wait_drain();
        write_end_symbol(SYM_W'($urandom_range(255)));
      end
      r = $urandom_range(99);
      if (r < 3) begin
        send_item(ACT_UNUSED, SYM_W'($urandom), CODE_LEN_W'($urandom), $urandom);
      end else if (r < 13) begin
        send_item(ACT_LOAD, SYM_W'($urandom), random_len(), $urandom);
        i++;
      end else if (r < 20) begin
        if (loaded[end_sym])
          send_item(ACT_FINISH, SYM_W'($urandom), CODE_LEN_W'($urandom), $urandom);
        else
          send_item(ACT_LOAD, end_sym, random_len(), $urandom);
        i++;
      end else begin
        s = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
        send_item(ACT_ENCODE, s, CODE_LEN_W'($urandom), $urandom);
        i++;
      end
    end
    calm = 1'b0;
  endtask

  // Check each popped word and decide pop for the next cycle
  initial begin : result_checker
    out_t want;
    int   hold_left;
    hold_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (pending_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual %h last %b",
                   $time, packed_word_o, last_word_o);
        end else begin
          want = pending_words.pop_front();
          if (packed_word_o !== want.word) begin
            errors++;
            $display("%0t: packed_word expected %h actual %h",
                     $time, want.word, packed_word_o);
          end
          if (last_word_o !== want.last) begin
            errors++;
            $display("%0t: last_word expected %b actual %b",
                     $time, want.last, last_word_o);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_request > 0) begin
        hold_left    = hold_request - 1;
        hold_request = 0;
        pop <= 1'b0;
      end else begin
        pop <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Abort a hung run
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_top: errors");
    $finish;
  end

  // Reset, run the tests in turn, then report
  initial begin
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    action_i    <= ACT_LOAD;
    symbol_i    <= '0;
    code_len_i  <= '0;
    code_bits_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_and_encode();
    test_finish_cases();
    test_end_symbol();
    test_backpressure();
    test_random_stream();
    wait_drain();
    if (errors == 0 && pending_words.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: huffman_table_encoder_packer_core.f
rtl/hte_pkg.sv
rtl/hte_front.sv
rtl/hte_cmd_queue.sv
rtl/hte_back.sv
rtl/huffman_table_encoder_packer_core.sv
rtl/hte_checker.sv
dv/tb_top.sv
